### sv/ptp_pkg.sv
// Package for the priority task picker: item types, function codes and sequencer states.
package ptp_pkg;

    // Milliseconds in one second, used to find the tick period.
    localparam int MS_PER_SECOND = 1000;

    // Bits of the sleep time.
    localparam int SLEEP_W = 16;

    typedef enum logic [1:0] {
        FUNC_PICK       = 2'd0,
        FUNC_LOAD_PRIO  = 2'd1,
        FUNC_SET_FLAGS  = 2'd2,
        FUNC_SLEEP_PICK = 2'd3
    } t_func;

    typedef struct packed {
        t_func               func;
        logic [2:0]          task_index;
        logic [7:0]          priority_value;
        logic                blocked_flag;
        logic                done_flag;
        logic [SLEEP_W-1:0]  sleep_ms;
        logic [31:0]         now_tick;
    } t_pick_in;

    typedef struct packed {
        logic [2:0] chosen_task;
        logic       found;
        logic       restarted;
    } t_pick_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_WAKE,
        S_CHECK,
        S_SCAN,
        S_UPDATE,
        S_RESP
    } t_state;

endpackage

### sv/priority_task_picker.sv
// Priority task picker: a table of task entries and a sequencer that scans it.
//
// The input channel (i_in_valid, o_in_stall, i_in) takes one command per transfer:
// pick, load a priority, set the blocked and done marks, or put the current task to
// sleep and then pick. Every command returns exactly one result transfer on the
// output channel (o_out_valid, i_out_stall, o_out).
// Load priority and set flags go from idle straight to the result state, which
// loads the result register. A pick runs a restart check, a scan that reads one
// entry per cycle through the table memories (with registered read data), a
// use-count update and the result state. Sleep first multiplies by the reciprocal
// of the tick period to turn milliseconds into ticks, then writes the wake tick,
// and then goes on as a pick.
// The block takes one command at a time; o_in_stall is high from the accepting
// edge until the sequencer returns to idle, so the next command can be taken
// only once the result register has loaded.
// A result waiting in the output register does not block a new command; only a
// second result has to wait. If the receiver stalls, the result register holds its
// value and the sequencer waits in its result cycle until it can be reloaded.
// Reset (synchronous, active low) empties the result register, clears the
// blocked and done marks and the valid bits of the priority, use-count and
// wake-tick memories, so all entries read as zero right away; no clearing pass.
module priority_task_picker
    import ptp_pkg::*;
#(
    parameter int TASKS        = 8,
    parameter int TICK_RATE_HZ = 100
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_pick_in  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_pick_out o_out
);

    localparam int IW       = $clog2(TASKS);
    localparam int PER_TICK = (MS_PER_SECOND / TICK_RATE_HZ > 0) ?
                              (MS_PER_SECOND / TICK_RATE_HZ) : 1;
    // Reciprocal of the tick period, exact for every sleep time of SLEEP_W bits.
    localparam int RECIP_SH = SLEEP_W + $clog2(PER_TICK);
    localparam int RECIP_M  = (1 << RECIP_SH) / PER_TICK + 1;
    localparam int RECIP_W  = SLEEP_W + 1;
    // Entries 0 to TASKS-2 take part in the restart check.
    localparam logic [TASKS-1:0] LOW_MASK = {1'b0, {(TASKS-1){1'b1}}};

    // Sequencer state and the command being worked on.
    t_state r_state, n_state;
    t_pick_in r_item;

    // Entry tables. Priority, use count and wake tick live in memories whose
    // entries read as zero until written, tracked by a valid bit per entry.
    logic [7:0]  prio_mem [TASKS];
    logic [31:0] use_mem  [TASKS];
    logic [31:0] wake_mem [TASKS];
    logic [TASKS-1:0] r_prio_vld, r_use_vld, r_wake_vld;
    logic [TASKS-1:0] r_blocked, r_done;
    logic [2:0] r_cur;

    // Sleep time in ticks, from a multiplication by the reciprocal.
    logic [SLEEP_W-1:0]         r_quo;
    logic [SLEEP_W+RECIP_W-1:0] div_prod;

    // Scan pipeline: read address counter, registered read data, running best.
    logic [IW:0]   r_issue;
    logic [IW-1:0] rd_addr;
    logic          r_cmp_v;
    logic [IW-1:0] r_cmp_idx;
    logic [7:0]    r_prio_q;
    logic [31:0]   r_use_q, r_wake_q;
    logic          r_prio_qv, r_use_qv, r_wake_qv;
    logic [7:0]    eff_prio;
    logic [31:0]   eff_use, eff_wake;
    logic          cand_run, cand_take;
    logic          r_have, r_restart;
    logic [IW-1:0] r_best;
    logic [7:0]    r_best_prio;
    logic [31:0]   r_best_use;

    // Result register.
    logic      r_out_valid;
    t_pick_out r_out;
    t_pick_out result;

    // Decoded controls.
    logic accept, in_idx_ok, cur_ok, all_done, scan_last;
    logic prio_we, flags_we, div_step, wake_we;
    logic check_en, scan_en, use_we, load_out;
    logic [IW-1:0] in_addr, cur_addr;

    assign in_idx_ok = ({4'b0, i_in.task_index} < 7'(TASKS));
    assign cur_ok    = ({4'b0, r_cur} < 7'(TASKS));
    assign in_addr   = IW'(i_in.task_index);
    assign cur_addr  = IW'(r_cur);
    assign all_done  = ((r_done & LOW_MASK) == LOW_MASK);
    assign rd_addr   = r_issue[IW-1:0];
    assign scan_last = r_cmp_v && (r_cmp_idx == IW'(TASKS - 1));

    // Milliseconds times the reciprocal; the quotient starts at bit RECIP_SH.
    assign div_prod = {{RECIP_W{1'b0}}, r_item.sleep_ms} * (SLEEP_W+RECIP_W)'(RECIP_M);

    // Candidate evaluation for the entry whose read data just arrived.
    assign eff_prio  = r_prio_qv ? r_prio_q : 8'd0;
    assign eff_use   = r_use_qv  ? r_use_q  : 32'd0;
    assign eff_wake  = r_wake_qv ? r_wake_q : 32'd0;
    assign cand_run  = (eff_wake <= r_item.now_tick) && !r_blocked[r_cmp_idx]
                       && !r_done[r_cmp_idx];
    assign cand_take = r_cmp_v && cand_run &&
                       (!r_have || (eff_prio > r_best_prio) ||
                        ((eff_prio == r_best_prio) && (eff_use < r_best_use)));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.func)
                        FUNC_PICK:       n_state = S_CHECK;
                        FUNC_SLEEP_PICK: n_state = S_DIV;
                        default:         n_state = S_RESP;
                    endcase
                end
            end
            S_DIV:    n_state = S_WAKE;
            S_WAKE:   n_state = S_CHECK;
            S_CHECK:  n_state = S_SCAN;
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_RESP;
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall = 1'b1;
        accept     = 1'b0;
        prio_we    = 1'b0;
        flags_we   = 1'b0;
        div_step   = 1'b0;
        wake_we    = 1'b0;
        check_en   = 1'b0;
        scan_en    = 1'b0;
        use_we     = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                accept     = i_in_valid;
                prio_we    = i_in_valid && (i_in.func == FUNC_LOAD_PRIO) && in_idx_ok;
                flags_we   = i_in_valid && (i_in.func == FUNC_SET_FLAGS) && in_idx_ok;
            end
            S_DIV:    div_step = 1'b1;
            S_WAKE:   wake_we  = cur_ok;
            S_CHECK:  check_en = 1'b1;
            S_SCAN:   scan_en  = 1'b1;
            S_UPDATE: use_we   = r_have;
            S_RESP:   load_out = !r_out_valid || !i_out_stall;
            default:  o_in_stall = 1'b1;
        endcase
    end

    // Result of the finished command; table writes report all zeros.
    always_comb begin
        result = '0;
        if (r_item.func == FUNC_PICK || r_item.func == FUNC_SLEEP_PICK) begin
            result.restarted = r_restart;
            result.found     = r_have;
            if (r_have) begin
                result.chosen_task = 3'(r_best);
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prio_vld  <= '0;
            r_use_vld   <= '0;
            r_wake_vld  <= '0;
            r_blocked   <= '0;
            r_done      <= '0;
            r_cur       <= '0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmp_v <= scan_en && (r_issue < (IW+1)'(TASKS));
            if (prio_we) begin
                r_prio_vld[in_addr] <= 1'b1;
            end
            if (flags_we) begin
                r_blocked[in_addr] <= i_in.blocked_flag;
                r_done[in_addr]    <= i_in.done_flag;
            end
            if (wake_we) begin
                r_wake_vld[cur_addr] <= 1'b1;
            end
            if (check_en && all_done) begin
                r_done    <= r_done & ~LOW_MASK;
                r_use_vld <= r_use_vld & ~LOW_MASK;
            end
            if (use_we) begin
                r_use_vld[r_best] <= 1'b1;
                r_cur             <= 3'(r_best);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
        end
        if (div_step) begin
            r_quo <= SLEEP_W'(div_prod >> RECIP_SH);
        end
        if (check_en) begin
            r_restart   <= all_done;
            r_have      <= 1'b0;
            r_best      <= '0;
            r_best_prio <= '0;
            r_best_use  <= '0;
            r_issue     <= '0;
        end else if (scan_en) begin
            if (r_issue < (IW+1)'(TASKS)) begin
                r_issue <= r_issue + (IW+1)'(1);
            end
            if (cand_take) begin
                r_have      <= 1'b1;
                r_best      <= r_cmp_idx;
                r_best_prio <= eff_prio;
                r_best_use  <= eff_use;
            end
        end
        if (load_out) begin
            r_out <= result;
        end
    end

    // Table memories with one write port and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (prio_we) begin
            prio_mem[in_addr] <= i_in.priority_value;
        end
        if (wake_we) begin
            wake_mem[cur_addr] <= r_item.now_tick + {{(32-SLEEP_W){1'b0}}, r_quo};
        end
        if (use_we) begin
            use_mem[r_best] <= (r_best_use == '1) ? r_best_use : (r_best_use + 32'd1);
        end
        r_prio_q  <= prio_mem[rd_addr];
        r_use_q   <= use_mem[rd_addr];
        r_wake_q  <= wake_mem[rd_addr];
        r_prio_qv <= r_prio_vld[rd_addr];
        r_use_qv  <= r_use_vld[rd_addr];
        r_wake_qv <= r_wake_vld[rd_addr];
        r_cmp_idx <= rd_addr;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Every accepted command moves the sequencer out of idle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted command did not start the sequencer");

    // The divider only runs for a sleep command.
    a_div_only_sleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_item.func == FUNC_SLEEP_PICK))
        else $error("divider running for a command without sleep");

    // A new result appears only after the result cycle of the sequencer.
    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_RESP))
        else $error("result appeared outside the result cycle");

    // A pick that finds nothing reports entry zero.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.found) |-> (o_out.chosen_task == 3'd0))
        else $error("chosen task set without a found task");

endmodule
